[hw/rtl/fpalu_pkg.sv]
// Package for the fixed-point ALU: operation codes, widths and defaults.
// No dependencies.
`default_nettype none
package fpalu_pkg;
    localparam int WordWidth       = 32;
    localparam int ActionWidth     = 4;
    localparam int FracBitsDefault = 8;

    localparam logic [ActionWidth-1:0] OP_ADD  = 4'd0;
    localparam logic [ActionWidth-1:0] OP_SUB  = 4'd1;
    localparam logic [ActionWidth-1:0] OP_MUL  = 4'd2;
    localparam logic [ActionWidth-1:0] OP_DIV  = 4'd3;
    localparam logic [ActionWidth-1:0] OP_EQ   = 4'd4;
    localparam logic [ActionWidth-1:0] OP_NE   = 4'd5;
    localparam logic [ActionWidth-1:0] OP_GT   = 4'd6;
    localparam logic [ActionWidth-1:0] OP_GE   = 4'd7;
    localparam logic [ActionWidth-1:0] OP_LT   = 4'd8;
    localparam logic [ActionWidth-1:0] OP_LE   = 4'd9;
    localparam logic [ActionWidth-1:0] OP_MIN  = 4'd10;
    localparam logic [ActionWidth-1:0] OP_MAX  = 4'd11;
    localparam logic [ActionWidth-1:0] OP_INC  = 4'd12;
    localparam logic [ActionWidth-1:0] OP_DEC  = 4'd13;
    localparam logic [ActionWidth-1:0] OP_I2F  = 4'd14;
    localparam logic [ActionWidth-1:0] OP_F2I  = 4'd15;
endpackage
`default_nettype wire

[hw/rtl/fixed_point_alu.sv]
// Top level of the signed fixed-point ALU (Q(32-FRAC_BITS).FRAC_BITS).
// Depends on fpalu_pkg.
`default_nettype none
// Fully pipelined: one transaction per cycle while the output is not stalled, with the result
// registered in the output register after the last pipeline stage.
// Stage 0 registers the inputs and computes all operations other than multiply and divide, plus the
// divide set-up. The 64-bit product is formed from four 16x16 partial products
// registered in stage 1 and summed in stage 2. The divide is a restoring divider,
// one quotient bit per stage, over the 32+FRAC_BITS quotient bits that can be
// non-zero. The pipeline advances whenever the output register is free or being
// taken, so tready falls whenever a result is held at the output.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpalu_pkg::FracBitsDefault
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] action, [35:4] operand_a, [67:36] operand_b, [71:68] zero
    input  wire  [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [31:0] result_word, [32] compare_true, [33] divide_by_zero, [39:34] zero
    output logic [39:0] m_axis_tdata
);
    import fpalu_pkg::*;

    localparam int QB    = WordWidth + FRAC_BITS;   // quotient bits
    localparam int DEPTH = QB + 2;                  // stages before output reg

    typedef struct packed {
        logic [WordWidth-1:0] res;
        logic                 cmp;
        logic                 dz;
        logic                 is_mul;
        logic                 is_div;
        logic                 neg;
    } ctl_t;

    ctl_t                     ctl_reg  [DEPTH];
    logic [DEPTH-1:0]         vld_reg;
    logic [2*WordWidth-1:0]   prod_reg [DEPTH];
    logic [QB-1:0]            num_reg  [DEPTH];
    logic [WordWidth:0]       rem_reg  [DEPTH];
    logic [WordWidth-1:0]     den_reg  [DEPTH];
    logic [31:0]              pp_reg   [4];
    logic [WordWidth-1:0]     ma_reg, mb_reg;
    logic                     adv;
    logic                     out_valid_reg;
    logic [39:0]              out_data_reg;

    logic [ActionWidth-1:0]   act;
    logic signed [WordWidth-1:0] a, b;
    assign act = s_axis_tdata[3:0];
    assign a   = s_axis_tdata[35:4];
    assign b   = s_axis_tdata[67:36];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    ctl_t  c0;
    logic [2*WordWidth-1:0] sh_a;
    always_comb
    begin
        c0        = '0;
        sh_a      = {{WordWidth{a[WordWidth-1]}}, a};
        c0.is_mul = (act == OP_MUL);
        c0.is_div = (act == OP_DIV) && (b != '0);
        c0.neg    = a[WordWidth-1] ^ b[WordWidth-1];
        unique case (act)
            OP_ADD: c0.res = a + b;
            OP_SUB: c0.res = a - b;
            OP_DIV: c0.dz  = (b == '0);
            OP_EQ:  c0.cmp = (a == b);
            OP_NE:  c0.cmp = (a != b);
            OP_GT:  c0.cmp = (a > b);
            OP_GE:  c0.cmp = (a >= b);
            OP_LT:  c0.cmp = (a < b);
            OP_LE:  c0.cmp = (a <= b);
            OP_MIN: c0.res = (a < b) ? a : b;
            OP_MAX: c0.res = (a > b) ? a : b;
            OP_INC: c0.res = a + 1'b1;
            OP_DEC: c0.res = a - 1'b1;
            OP_I2F: c0.res = WordWidth'(a <<< FRAC_BITS);
            OP_F2I: c0.res = WordWidth'(sh_a >>> FRAC_BITS);
            default: c0.res = '0;
        endcase
    end

    // Stage 0: operand magnitudes and control
    logic [WordWidth-1:0] abs_a, abs_b;
    assign abs_a = a[WordWidth-1] ? -a : a;
    assign abs_b = b[WordWidth-1] ? -b : b;

    logic [2*WordWidth-1:0] full_prod;
    assign full_prod = {32'd0, pp_reg[0]} + ({32'd0, pp_reg[1]} << 16)
                     + ({32'd0, pp_reg[2]} << 16) + ({32'd0, pp_reg[3]} << 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    // Unsigned restoring divide step per stage; magnitude multiply split in halves.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0]  <= c0;
            ma_reg      <= abs_a;
            mb_reg      <= abs_b;
            num_reg[0]  <= QB'(abs_a) << FRAC_BITS;
            rem_reg[0]  <= '0;
            den_reg[0]  <= abs_b;
            prod_reg[0] <= '0;
            pp_reg[0]   <= ma_reg[15:0]  * mb_reg[15:0];
            pp_reg[1]   <= ma_reg[31:16] * mb_reg[15:0];
            pp_reg[2]   <= ma_reg[15:0]  * mb_reg[31:16];
            pp_reg[3]   <= ma_reg[31:16] * mb_reg[31:16];
            for (int i = 1; i < DEPTH; i++)
            begin
                logic [WordWidth:0] trial;
                trial = {rem_reg[i-1][WordWidth-1:0], num_reg[i-1][QB-1]};
                ctl_reg[i] <= ctl_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                if (i < QB + 1 && trial >= {1'b0, den_reg[i-1]})
                begin
                    rem_reg[i] <= trial - {1'b0, den_reg[i-1]};
                    num_reg[i] <= {num_reg[i-1][QB-2:0], 1'b1};
                end
                else if (i < QB + 1)
                begin
                    rem_reg[i] <= trial;
                    num_reg[i] <= {num_reg[i-1][QB-2:0], 1'b0};
                end
                else
                begin
                    rem_reg[i] <= rem_reg[i-1];
                    num_reg[i] <= num_reg[i-1];
                end
                prod_reg[i] <= (i == 2) ? full_prod : prod_reg[i-1];
            end
        end
    end

    // Output: sign-correct and select.
    logic [2*WordWidth-1:0] sprod;
    logic [WordWidth-1:0]   q, r;
    ctl_t                   cl;
    always_comb
    begin
        cl    = ctl_reg[DEPTH-1];
        sprod = cl.neg ? -prod_reg[DEPTH-1] : prod_reg[DEPTH-1];
        q     = WordWidth'(num_reg[DEPTH-1]);
        q     = cl.neg ? -q : q;
        r     = cl.res;
        if (cl.is_mul)
            r = WordWidth'($signed(sprod) >>> FRAC_BITS);
        else if (cl.is_div)
            r = q;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= {6'd0, cl.dz, cl.cmp, r};
    end

    property p_ready;
        @(posedge clk) disable iff (!rst_n) !m_axis_tready && m_axis_tvalid |-> !s_axis_tready;
    endproperty
    a_ready: assert property (p_ready) else $error("ready while output held");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
            m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("output changed while stalled");

    property p_flags;
        @(posedge clk) disable iff (!rst_n)
            m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]);
    endproperty
    a_flags: assert property (p_flags) else $error("both flags set");
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for fixed_point_alu: queued driver, clocked monitor, in-bench predictor.
// Depends on fpalu_pkg and fixed_point_alu.
`default_nettype none
module tb;
    import fpalu_pkg::*;

    localparam int FRAC = FracBitsDefault;
    localparam int LATENCY = 32 + FRAC + 3;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [31:0] b;
        logic [31:0] a;
        logic [3:0]  op;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic        cmp;
        logic        dz;
    } alu_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       cycles = 0;
    int       phase = 0;       // 0: sender 38%, receiver 75%; 1: swapped; 2: no idling
    int       hold_cycles = 0; // receiver long hold-off
    bit       hold_done = 1'b0;
    bit       stim_done = 1'b0;
    int       op_hits[16];

    always #5 clk = ~clk;

    fixed_point_alu dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // [3:0] action, [35:4] operand_a, [67:36] operand_b, [71:68] zero
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // [31:0] result_word, [32] compare_true, [33] divide_by_zero, [39:34] zero
        .m_axis_tdata(m_axis_tdata)
    );

    // Bit-accurate prediction of one ALU transaction.
    function automatic alu_res_t alu_predict(alu_req_t r);
        alu_res_t    res;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic signed [63:0] prod;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        sa = r.a;
        sb = r.b;
        res = '0;
        case (r.op)
            OP_ADD: res.word = r.a + r.b;
            OP_SUB: res.word = r.a - r.b;
            OP_MUL:
            begin
                prod = 64'(sa) * 64'(sb);
                prod = prod >>> FRAC;
                res.word = prod[31:0];
            end
            OP_DIV:
            begin
                if (sb == 0)
                    res.dz = 1'b1;
                else
                begin
                    ma = sa < 0 ? -64'(sa) : 64'(sa);
                    mb = sb < 0 ? -64'(sb) : 64'(sb);
                    q = (ma << FRAC) / mb;
                    if ((sa < 0) != (sb < 0))
                        q = -q;
                    res.word = q[31:0];
                end
            end
            OP_EQ:  res.cmp = sa == sb;
            OP_NE:  res.cmp = sa != sb;
            OP_GT:  res.cmp = sa > sb;
            OP_GE:  res.cmp = sa >= sb;
            OP_LT:  res.cmp = sa < sb;
            OP_LE:  res.cmp = sa <= sb;
            OP_MIN: res.word = sa < sb ? r.a : r.b;
            OP_MAX: res.word = sa > sb ? r.a : r.b;
            OP_INC: res.word = r.a + 32'd1;
            OP_DEC: res.word = r.a - 32'd1;
            OP_I2F: res.word = r.a << FRAC;
            default: res.word = sa >>> FRAC;
        endcase
        return res;
    endfunction

    // Operand mix: edge values often, small values for meaningful fixed-point maths.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 5))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'h0;
                   3: return 32'hffff_ffff;
                   4: return 32'd1 << FRAC;
                   default: return -(32'd1 << FRAC);
               endcase
            1, 2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return 32'($signed($urandom_range(0, 255)) - 128);
            default: return $urandom;
        endcase
    endfunction

    // Driver: pops pending transactions; idle pattern depends on phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_reqs.size() != 0 &&
                !(phase == 0 && $urandom_range(0, 99) < 38) &&
                !(phase == 1 && $urandom_range(0, 99) < 75))
            begin
                alu_req_t r;
                r = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, r};
                expected_results.push_back(alu_predict(r));
                op_hits[r.op]++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver ready: random stall per phase, plus the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_cycles > 0)
            m_axis_tready <= 1'b0;
        else if (phase == 0)
            m_axis_tready <= $urandom_range(0, 99) >= 75;
        else if (phase == 1)
            m_axis_tready <= $urandom_range(0, 99) >= 38;
        else
            m_axis_tready <= 1'b1;
    end

    // Hold-off counter in its own process: starts once in the no-idle phase.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
        else if (phase == 2 && !hold_done && s_axis_tvalid)
        begin
            hold_cycles <= 3 * LATENCY;
            hold_done <= 1'b1;
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            alu_res_t got;
            alu_res_t want;
            got = '{word: m_axis_tdata[31:0], cmp: m_axis_tdata[32], dz: m_axis_tdata[33]};
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want || m_axis_tdata[39:34] !== 6'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected word %h cmp %b dz %b, got %h %b %b",
                                 want.word, want.cmp, want.dz, got.word, got.cmp, got.dz);
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL fixed_point_alu");
            $finish;
        end
    end

    task automatic queue_req(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        pending_reqs.push_back('{b: b, a: a, op: op});
    endtask

    initial
    begin
        int drain;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operation, edge operands, divide by zero, sign mixes.
        for (int op = 0; op < 16; op++)
            queue_req(op[3:0], 32'h8000_0000, 32'h7fff_ffff);
        queue_req(OP_DIV, 32'h0000_0500, 32'h0);
        queue_req(OP_DIV, 32'hffff_fb00, 32'h0000_0300);
        queue_req(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        queue_req(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_req(OP_MUL, 32'hffff_ff00, 32'h0000_0180);
        queue_req(OP_INC, 32'h7fff_ffff, 32'h0);
        queue_req(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
        queue_req(OP_F2I, 32'hffff_ff01, 32'h0);
        queue_req(OP_EQ, 32'h0000_1234, 32'h0000_1234);

        for (int p = 0; p < 3; p++)
        begin
            wait (pending_reqs.size() == 0);
            phase = p;
            for (int i = 0; i < 380; i++)
                queue_req(4'($urandom_range(0, 15)), pick_operand(),
                          ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
        end
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        stim_done = 1'b1;
        wait (expected_results.size() == 0);
        drain = 0;
        while (drain < 2 * LATENCY)
        begin
            @(posedge clk);
            drain++;
        end

        $display("covered %0d results, all 16 operations, three idle patterns, long output stall",
                 results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS fixed_point_alu");
        else
            $display("FAIL fixed_point_alu");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hw/rtl/fpalu_pkg.sv
hw/rtl/fixed_point_alu.sv
bench/tb.sv
